>>> src/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared widths, fixed-point constants and pipeline payload types of the
// RGB to HSL converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsl_pkg;

	// Field widths.
	localparam int unsigned CH_W  = 8;   // one color channel
	localparam int unsigned HUE_W = 17;  // hue, degrees * 256
	localparam int unsigned PCT_W = 15;  // saturation and lightness, percent * 256
	localparam int unsigned SUM_W = 9;   // max + min

	// Divider geometry. Every quotient stays below 2**QUO_W, so the division
	// starts with the numerator bits above QUO_W already in the remainder.
	localparam int unsigned QUO_W      = 15;
	localparam int unsigned REM_W      = SUM_W;
	localparam int unsigned NUM_W      = QUO_W + REM_W;
	localparam int unsigned DIV_STAGES = QUO_W;

	// Fixed-point constants.
	localparam int unsigned HUE_SECTOR = 15360;  // 60 degrees
	localparam int unsigned HUE_GREEN  = 30720;  // 120 degrees
	localparam int unsigned HUE_BLUE   = 61440;  // 240 degrees
	localparam int unsigned HUE_FULL   = 92160;  // 360 degrees
	localparam int unsigned PCT_ONE    = 25600;  // 100 percent
	localparam int unsigned SUM_FULL   = 510;
	localparam int unsigned SUM_HALF   = 255;

	// Lightness is sum * 12800 / 255. The product of sum and this reciprocal,
	// shifted right by LIG_SHIFT, gives the floor exactly for every sum up to 510.
	localparam int unsigned LIG_RECIP = 6579301;
	localparam int unsigned LIG_SHIFT = 17;

	typedef enum logic [1:0] {
		SECT_RED   = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE  = 2'd2
	} sect_t;

	typedef struct packed {
		sect_t sect;
		logic  neg;
		logic  gray;
	} hue_ctl_t;

	// One division in flight: partial remainder, the numerator bits not yet
	// consumed with the quotient bits shifted in behind them, and the divisor.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] nq;
		logic [REM_W-1:0] den;
	} lane_t;

	typedef struct packed {
		hue_ctl_t         ctl;
		lane_t            hue;
		lane_t            sat;
		logic [PCT_W-1:0] lig;
	} div_t;

endpackage

`default_nettype wire

>>> src/rgbhsl_pix_if.sv
// ----------------------------------------------------------------------------
// rgbhsl_pix_if
// Pixel channel: valid/ready handshake with one RGB pixel as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbhsl_pix_if;
	logic                          valid;
	logic                          ready;
	logic [rgbhsl_pkg::CH_W-1:0]   red;
	logic [rgbhsl_pkg::CH_W-1:0]   green;
	logic [rgbhsl_pkg::CH_W-1:0]   blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> src/rgbhsl_hsl_if.sv
// ----------------------------------------------------------------------------
// rgbhsl_hsl_if
// Result channel: valid/ready handshake with hue, saturation and lightness.
// ----------------------------------------------------------------------------
`default_nettype none

interface rgbhsl_hsl_if;
	logic                          valid;
	logic                          ready;
	logic [rgbhsl_pkg::HUE_W-1:0]  hue;
	logic [rgbhsl_pkg::PCT_W-1:0]  saturation;
	logic [rgbhsl_pkg::PCT_W-1:0]  lightness;

	modport source (output valid, output hue, output saturation, output lightness,
		input ready);
	modport sink   (input valid, input hue, input saturation, input lightness,
		output ready);
endinterface

`default_nettype wire

>>> src/rgbhsl_front.sv
// ----------------------------------------------------------------------------
// rgbhsl_front
// Two pipeline stages: channel max/min and hue sector, then the scaled
// numerators and divisors of the hue and saturation divisions and the
// lightness.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsl_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [rgbhsl_pkg::CH_W-1:0] red,
	input  logic [rgbhsl_pkg::CH_W-1:0] green,
	input  logic [rgbhsl_pkg::CH_W-1:0] blue,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rgbhsl_pkg::div_t            out_data
);

	logic [rgbhsl_pkg::CH_W-1:0]  ch_max, ch_min, op_a, op_b;
	logic [rgbhsl_pkg::CH_W-1:0]  delta_c, mag_c;
	rgbhsl_pkg::sect_t            sect_c;

	logic                         vld_s1, vld_s2;
	logic                         en_s1, en_s2;
	rgbhsl_pkg::hue_ctl_t         ctl_s1;
	logic [rgbhsl_pkg::CH_W-1:0]  delta_s1, mag_s1;
	logic [rgbhsl_pkg::SUM_W-1:0] sum_s1;
	rgbhsl_pkg::div_t             div_c, div_s2;

	logic [rgbhsl_pkg::NUM_W-1:0] num_hue, num_sat;
	logic [rgbhsl_pkg::SUM_W-1:0] den_sat;
	logic [31:0]                  lig_prod;

	// Stage 1: extremes and sector choice. Ties go to red, then green.
	always_comb begin
		ch_max = red;
		ch_min = red;
		if (green > ch_max) ch_max = green;
		if (blue  > ch_max) ch_max = blue;
		if (green < ch_min) ch_min = green;
		if (blue  < ch_min) ch_min = blue;
		delta_c = ch_max - ch_min;

		priority if (red >= green && red >= blue) begin
			sect_c = rgbhsl_pkg::SECT_RED;
			op_a   = green;
			op_b   = blue;
		end else if (green >= blue) begin
			sect_c = rgbhsl_pkg::SECT_GREEN;
			op_a   = blue;
			op_b   = red;
		end else begin
			sect_c = rgbhsl_pkg::SECT_BLUE;
			op_a   = red;
			op_b   = green;
		end
		mag_c = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);
	end

	assign en_s2    = !vld_s2 || out_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			ctl_s1.sect <= sect_c;
			ctl_s1.neg  <= (op_a < op_b);
			ctl_s1.gray <= (delta_c == '0);
			delta_s1    <= delta_c;
			mag_s1      <= mag_c;
			sum_s1      <= rgbhsl_pkg::SUM_W'(ch_max) + rgbhsl_pkg::SUM_W'(ch_min);
		end
	end

	// Stage 2: constant scaling and divisor selection.
	always_comb begin
		num_hue  = rgbhsl_pkg::NUM_W'(32'(rgbhsl_pkg::HUE_SECTOR) * 32'(mag_s1));
		num_sat  = rgbhsl_pkg::NUM_W'(32'(rgbhsl_pkg::PCT_ONE) * 32'(delta_s1));
		lig_prod = 32'(sum_s1) * 32'(rgbhsl_pkg::LIG_RECIP);
		den_sat  = (sum_s1 <= rgbhsl_pkg::SUM_W'(rgbhsl_pkg::SUM_HALF)) ? sum_s1 :
			(rgbhsl_pkg::SUM_W'(rgbhsl_pkg::SUM_FULL) - sum_s1);

		div_c.ctl     = ctl_s1;
		div_c.hue.rem = num_hue[rgbhsl_pkg::NUM_W-1:rgbhsl_pkg::QUO_W];
		div_c.hue.nq  = num_hue[rgbhsl_pkg::QUO_W-1:0];
		div_c.hue.den = rgbhsl_pkg::REM_W'(delta_s1);
		div_c.sat.rem = num_sat[rgbhsl_pkg::NUM_W-1:rgbhsl_pkg::QUO_W];
		div_c.sat.nq  = num_sat[rgbhsl_pkg::QUO_W-1:0];
		div_c.sat.den = den_sat;
		div_c.lig     = lig_prod[rgbhsl_pkg::LIG_SHIFT +: rgbhsl_pkg::PCT_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			div_s2 <= div_c;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = div_s2;

endmodule

`default_nettype wire

>>> src/rgbhsl_div.sv
// ----------------------------------------------------------------------------
// rgbhsl_div
// Pipelined restoring divider: the hue and saturation divisions side by side,
// one quotient bit per stage for each; the lightness rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsl_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rgbhsl_pkg::div_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rgbhsl_pkg::div_t out_data
);

	function automatic rgbhsl_pkg::lane_t lane_step(input rgbhsl_pkg::lane_t l);
		logic [rgbhsl_pkg::REM_W:0] trial;
		logic                       ge;
		rgbhsl_pkg::lane_t          r;
		trial = {l.rem, l.nq[rgbhsl_pkg::QUO_W-1]};
		ge    = (trial >= {1'b0, l.den});
		r.den = l.den;
		r.rem = ge ? rgbhsl_pkg::REM_W'(trial - {1'b0, l.den}) : rgbhsl_pkg::REM_W'(trial);
		r.nq  = {l.nq[rgbhsl_pkg::QUO_W-2:0], ge};
		return r;
	endfunction

	function automatic rgbhsl_pkg::div_t div_step(input rgbhsl_pkg::div_t d);
		rgbhsl_pkg::div_t r;
		r.ctl = d.ctl;
		r.hue = lane_step(d.hue);
		r.sat = lane_step(d.sat);
		r.lig = d.lig;
		return r;
	endfunction

	logic             vld_s [rgbhsl_pkg::DIV_STAGES];
	rgbhsl_pkg::div_t dat_s [rgbhsl_pkg::DIV_STAGES];
	logic             src_v [rgbhsl_pkg::DIV_STAGES];
	rgbhsl_pkg::div_t src_d [rgbhsl_pkg::DIV_STAGES];
	logic             rdy   [rgbhsl_pkg::DIV_STAGES+1];

	assign rdy[rgbhsl_pkg::DIV_STAGES] = out_ready;

	genvar k;
	generate
		for (k = 0; k < rgbhsl_pkg::DIV_STAGES; k++) begin : g_stage
			if (k == 0) begin : g_head
				assign src_v[k] = in_valid;
				assign src_d[k] = in_data;
			end else begin : g_body
				assign src_v[k] = vld_s[k-1];
				assign src_d[k] = dat_s[k-1];
			end

			// A stage takes a new request when it is empty or its content moves on.
			assign rdy[k] = !vld_s[k] || rdy[k+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					vld_s[k] <= src_v[k];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && src_v[k]) begin
					dat_s[k] <= div_step(src_d[k]);
				end
			end
		end
	endgenerate

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[rgbhsl_pkg::DIV_STAGES-1];
	assign out_data  = dat_s[rgbhsl_pkg::DIV_STAGES-1];

`ifndef SYNTH
	// A finished division of a non-gray pixel leaves a remainder below its divisor.
	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ctl.gray |-> out_data.hue.rem < out_data.hue.den)
		else $error("hue division remainder not below divisor");

	a_sat_rem: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ctl.gray |-> out_data.sat.rem < out_data.sat.den)
		else $error("saturation division remainder not below divisor");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled division request changed");
`endif

endmodule

`default_nettype wire

>>> src/rgbhsl_back.sv
// ----------------------------------------------------------------------------
// rgbhsl_back
// Output stage: places the hue term in its sector, clears gray pixels and
// holds the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsl_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rgbhsl_pkg::div_t             in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rgbhsl_pkg::HUE_W-1:0] hue,
	output logic [rgbhsl_pkg::PCT_W-1:0] saturation,
	output logic [rgbhsl_pkg::PCT_W-1:0] lightness
);

	logic [rgbhsl_pkg::HUE_W-1:0] term, base, hue_c;
	logic [rgbhsl_pkg::PCT_W-1:0] sat_c;
	logic                         en;
	logic                         vld_s18;
	logic [rgbhsl_pkg::HUE_W-1:0] hue_s18;
	logic [rgbhsl_pkg::PCT_W-1:0] sat_s18, lig_s18;

	always_comb begin
		term = rgbhsl_pkg::HUE_W'(in_data.hue.nq);
		unique case (in_data.ctl.sect)
			rgbhsl_pkg::SECT_RED:   base = in_data.ctl.neg ?
				rgbhsl_pkg::HUE_W'(rgbhsl_pkg::HUE_FULL) : '0;
			rgbhsl_pkg::SECT_GREEN: base = rgbhsl_pkg::HUE_W'(rgbhsl_pkg::HUE_GREEN);
			rgbhsl_pkg::SECT_BLUE:  base = rgbhsl_pkg::HUE_W'(rgbhsl_pkg::HUE_BLUE);
			default:                base = '0;
		endcase
		if (in_data.ctl.gray) begin
			hue_c = '0;
			sat_c = '0;
		end else begin
			hue_c = in_data.ctl.neg ? (base - term) : (base + term);
			sat_c = in_data.sat.nq;
		end
	end

	assign en       = !vld_s18 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s18 <= 1'b0;
		end else if (en) begin
			vld_s18 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			hue_s18 <= hue_c;
			sat_s18 <= sat_c;
			lig_s18 <= in_data.lig;
		end
	end

	assign out_valid  = vld_s18;
	assign hue        = hue_s18;
	assign saturation = sat_s18;
	assign lightness  = lig_s18;

`ifndef SYNTH
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> hue <= rgbhsl_pkg::HUE_W'(rgbhsl_pkg::HUE_FULL))
		else $error("hue beyond full circle");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> saturation <= rgbhsl_pkg::PCT_W'(rgbhsl_pkg::PCT_ONE))
		else $error("saturation beyond one hundred percent");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({hue, saturation, lightness}))
		else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

>>> src/rgb_to_hsl_convert.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert
// RGB to HSL converter, 8-bit channels in, percent and degree fixed point out.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock when the result side does not
// stall, and returns hue, saturation and lightness: two stages find the
// extremes, scale the numerators and form the lightness by a constant
// reciprocal multiplication, a 15-stage restoring divider produces
// one quotient bit per stage for the hue and saturation divisions at once, and
// a last stage places the hue and holds the result. Every stage has its own
// valid bit and moves whenever it is empty or its successor moves, so a
// stalled result leaves the stages behind it free to fill; no state carries
// from one pixel to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsl_convert (
	input  logic                clk,
	input  logic                arst_n,
	rgbhsl_pix_if.sink          pix,
	rgbhsl_hsl_if.source        hsl
);

	logic             fd_valid, fd_ready;
	rgbhsl_pkg::div_t fd_data;
	logic             db_valid, db_ready;
	rgbhsl_pkg::div_t db_data;

	rgbhsl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.red       (pix.red),
		.green     (pix.green),
		.blue      (pix.blue),
		.out_valid (fd_valid),
		.out_ready (fd_ready),
		.out_data  (fd_data)
	);

	rgbhsl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fd_valid),
		.in_ready  (fd_ready),
		.in_data   (fd_data),
		.out_valid (db_valid),
		.out_ready (db_ready),
		.out_data  (db_data)
	);

	rgbhsl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (db_valid),
		.in_ready   (db_ready),
		.in_data    (db_data),
		.out_valid  (hsl.valid),
		.out_ready  (hsl.ready),
		.hue        (hsl.hue),
		.saturation (hsl.saturation),
		.lightness  (hsl.lightness)
	);

endmodule

`default_nettype wire

>>> dv/rgb_to_hsl_convert_test.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert_test
// Self-checking testbench of the RGB to HSL converter. Directed pixels cover
// gray, every hue sector, tied maxima and the two saturation divisors; a long
// random stream follows. Each accepted pixel is converted by an integer
// predictor and the expected HSL triple is queued. A checker compares every
// accepted result with the oldest expectation, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_to_hsl_convert_test;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned SETTLE_TIME  = 40;
	localparam int unsigned RANDOM_ITEMS = 1880;
	localparam int unsigned CALM_ITEMS   = 250;

	typedef struct packed {
		logic [rgbhsl_pkg::HUE_W-1:0] hue;
		logic [rgbhsl_pkg::PCT_W-1:0] sat;
		logic [rgbhsl_pkg::PCT_W-1:0] lig;
	} hsl_pixel_t;

	logic clk;
	logic arst_n;

	rgbhsl_pix_if pix_bus ();
	rgbhsl_hsl_if hsl_bus ();

	rgb_to_hsl_convert dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_bus),
		.hsl    (hsl_bus)
	);

	hsl_pixel_t  pending_hsl[$];
	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	bit          throttle;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Integer conversion of one pixel; every division rounds down.
	function automatic hsl_pixel_t hsl_of_pixel(logic [rgbhsl_pkg::CH_W-1:0] r,
		logic [rgbhsl_pkg::CH_W-1:0] g, logic [rgbhsl_pkg::CH_W-1:0] b);
		int unsigned mx, mn, delta, sum, base, lead, trail, term, hue, sat;
		hsl_pixel_t res;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		sum = mx + mn;
		hue = 0;
		sat = 0;
		if (delta != 0) begin
			// Red beats green and green beats blue when maxima tie.
			if (mx == r) begin
				base = 0;
				lead = g;
				trail = b;
			end else if (mx == g) begin
				base = rgbhsl_pkg::HUE_GREEN;
				lead = b;
				trail = r;
			end else begin
				base = rgbhsl_pkg::HUE_BLUE;
				lead = r;
				trail = g;
			end
			if (lead >= trail) begin
				term = (rgbhsl_pkg::HUE_SECTOR * (lead - trail)) / delta;
				hue = base + term;
			end else begin
				term = (rgbhsl_pkg::HUE_SECTOR * (trail - lead)) / delta;
				// A negative difference in the red sector wraps around 360 degrees.
				hue = ((base == 0) ? rgbhsl_pkg::HUE_FULL : base) - term;
			end
			if (sum <= rgbhsl_pkg::SUM_HALF)
				sat = (rgbhsl_pkg::PCT_ONE * delta) / sum;
			else
				sat = (rgbhsl_pkg::PCT_ONE * delta) / (rgbhsl_pkg::SUM_FULL - sum);
		end
		res.hue = rgbhsl_pkg::HUE_W'(hue);
		res.sat = rgbhsl_pkg::PCT_W'(sat);
		res.lig = rgbhsl_pkg::PCT_W'((rgbhsl_pkg::PCT_ONE * sum) / rgbhsl_pkg::SUM_FULL);
		return res;
	endfunction

	task automatic send_pixel(input logic [rgbhsl_pkg::CH_W-1:0] r,
		input logic [rgbhsl_pkg::CH_W-1:0] g, input logic [rgbhsl_pkg::CH_W-1:0] b);
		if (throttle && $urandom_range(0, 11) == 0) begin
			pix_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.red   <= r;
		pix_bus.green <= g;
		pix_bus.blue  <= b;
		do @(posedge clk); while (!pix_bus.ready);
		pending_hsl.push_back(hsl_of_pixel(r, g, b));
	endtask

	task automatic wait_results_drained();
		pix_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending_hsl.size() != 0) @(posedge clk);
	endtask

	task automatic test_gray_pixels();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd254, 8'd254, 8'd254);
	endtask

	task automatic test_hue_sectors();
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd64, 8'd0);
		send_pixel(8'd255, 8'd0, 8'd64);
		send_pixel(8'd0, 8'd255, 8'd64);
		send_pixel(8'd64, 8'd255, 8'd0);
		send_pixel(8'd64, 8'd0, 8'd255);
		send_pixel(8'd0, 8'd64, 8'd255);
		// Tied maxima pick the earlier channel's sector.
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd200, 8'd10);
	endtask

	task automatic test_saturation_split();
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd128, 8'd127, 8'd127);
		send_pixel(8'd129, 8'd127, 8'd128);
		send_pixel(8'd255, 8'd254, 8'd254);
	endtask

	task automatic test_random_pixels(input int unsigned count);
		logic [rgbhsl_pkg::CH_W-1:0] r, g, b, v;
		int unsigned k;
		for (int unsigned n = 0; n < count; n++) begin
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
			v = 8'($urandom);
			case ($urandom_range(0, 9))
				0: begin
					r = v;
					g = v;
					b = v;
				end
				1: begin
					k = $urandom_range(0, 2);
					if (k == 0) g = r;
					else if (k == 1) b = g;
					else b = r;
				end
				2: begin
					// Near-gray pixels give tiny deltas.
					g = (v > 8'd250) ? v - 8'($urandom_range(0, 3)) : v + 8'($urandom_range(0, 3));
					b = (v > 8'd250) ? v - 8'($urandom_range(0, 3)) : v + 8'($urandom_range(0, 3));
					r = v;
				end
				default: ;
			endcase
			if (n == count / 2) wait_results_drained();
			send_pixel(r, g, b);
		end
	endtask

	// Result side: random stall bursts while throttling is on.
	initial begin
		hsl_bus.ready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (throttle && $urandom_range(0, 9) == 0) begin
				hsl_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			hsl_bus.ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		hsl_pixel_t want;
		if (arst_n && hsl_bus.valid && hsl_bus.ready) begin
			if (pending_hsl.size() == 0) begin
				$display("%0t: unexpected result hue=%0d sat=%0d lig=%0d", $time,
					hsl_bus.hue, hsl_bus.saturation, hsl_bus.lightness);
				mismatch_count++;
			end else begin
				want = pending_hsl.pop_front();
				if (hsl_bus.hue !== want.hue) begin
					$display("%0t: hue expected %0d actual %0d", $time, want.hue, hsl_bus.hue);
					mismatch_count++;
				end
				if (hsl_bus.saturation !== want.sat) begin
					$display("%0t: saturation expected %0d actual %0d", $time, want.sat,
						hsl_bus.saturation);
					mismatch_count++;
				end
				if (hsl_bus.lightness !== want.lig) begin
					$display("%0t: lightness expected %0d actual %0d", $time, want.lig,
						hsl_bus.lightness);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (pix_bus.valid && pix_bus.ready) || (hsl_bus.valid && hsl_bus.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		mismatch_count = 0;
		quiet_cycles   = 0;
		throttle       = 1'b1;
		arst_n         = 1'b0;
		pix_bus.valid  = 1'b0;
		pix_bus.red    = '0;
		pix_bus.green  = '0;
		pix_bus.blue   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_gray_pixels();
		test_hue_sectors();
		test_saturation_split();
		wait_results_drained();
		test_random_pixels(RANDOM_ITEMS - CALM_ITEMS);
		// Last stretch runs at full rate on both sides.
		throttle = 1'b0;
		test_random_pixels(CALM_ITEMS);

		pix_bus.valid <= 1'b0;
		while (pending_hsl.size() != 0) @(posedge clk);
		repeat (SETTLE_TIME) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
